// ===== rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 keystream cipher.
// Used by rc4_core and rc4_keystream_cipher; depends on nothing.
package rc4_pkg;

    localparam int BYTE_W = 8;
    localparam int SKIP_W = 16;

    // Request opcodes.
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              last_out;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_SW_I,
        ST_KS_SW_J,
        ST_INIT,
        ST_MIX_RD,
        ST_MIX_J,
        ST_MIX_SW_N,
        ST_MIX_SW_J,
        ST_SKIP_CHK
    } t_state;

endpackage

// ===== rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the old contents. No dependencies.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rc4_core.sv =====
// RC4 sequencer: clearing pass, key schedule, discard loop and keystream steps; the i, j
// and output-index sums all go through one shared 8-bit adder. Depends on rc4_pkg and rc4_ram.
module rc4_core #(
    parameter int KEY_BYTES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  rc4_pkg::t_in                 i_req,
    input  logic [rc4_pkg::SKIP_W-1:0]   i_skip_count,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output rc4_pkg::t_out                o_res
);

    localparam int KA_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int LEN_W = $clog2(KEY_BYTES + 1);
    localparam int BW    = rc4_pkg::BYTE_W;

    rc4_pkg::t_state r_state;
    rc4_pkg::t_state n_state;

    logic [BW-1:0]                r_n;
    logic [BW-1:0]                r_i;
    logic [BW-1:0]                r_j;
    logic [BW-1:0]                r_a;
    logic [BW-1:0]                r_b;
    logic [BW-1:0]                r_value;
    logic                         r_last;
    logic                         r_skip;
    logic [KA_W-1:0]              r_kidx;
    logic [LEN_W-1:0]             r_key_len;
    logic [rc4_pkg::SKIP_W-1:0]   r_skip_cnt;

    // Shared adder operands and result.
    logic [BW-1:0] add_a;
    logic [BW-1:0] add_b;
    logic [BW-1:0] add_c;
    logic [BW-1:0] sum;

    logic          p_we;
    logic [BW-1:0] p_waddr;
    logic [BW-1:0] p_wdata;
    logic [BW-1:0] p_raddr;
    logic [BW-1:0] p_rdata;

    logic          k_we;
    logic [BW-1:0] k_rdata;

    logic          req_fire;
    logic          key_room;
    logic [BW-1:0] ks;

    assign sum      = add_a + add_b + add_c;
    assign req_fire = i_req_valid && o_req_ready;
    assign key_room = (r_key_len < LEN_W'(KEY_BYTES));

    // The swap may have overtaken the output read: patch it from the swapped pair.
    assign ks = (sum == r_i) ? r_b : ((sum == r_j) ? r_a : p_rdata);

    rc4_ram #(.WIDTH(BW), .DEPTH(256)) u_perm (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    rc4_ram #(.WIDTH(BW), .DEPTH(KEY_BYTES)) u_key (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_key_len[KA_W-1:0]),
        .i_wdata (i_req.value),
        .i_raddr (r_kidx),
        .o_rdata (k_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rc4_pkg::ST_CLEAR: begin
                if (r_n == '1) n_state = rc4_pkg::ST_IDLE;
            end
            rc4_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.opcode == rc4_pkg::OP_DATA) begin
                        n_state = rc4_pkg::ST_KS_RD_I;
                    end else if (i_req.last) begin
                        n_state = rc4_pkg::ST_INIT;
                    end
                end
            end
            rc4_pkg::ST_KS_RD_I: n_state = rc4_pkg::ST_KS_RD_J;
            rc4_pkg::ST_KS_RD_J: n_state = rc4_pkg::ST_KS_SW_I;
            rc4_pkg::ST_KS_SW_I: n_state = rc4_pkg::ST_KS_SW_J;
            rc4_pkg::ST_KS_SW_J: begin
                if (r_skip) begin
                    n_state = rc4_pkg::ST_SKIP_CHK;
                end else if (i_res_ready) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            rc4_pkg::ST_INIT: begin
                if (r_n == '1) n_state = rc4_pkg::ST_MIX_RD;
            end
            rc4_pkg::ST_MIX_RD:   n_state = rc4_pkg::ST_MIX_J;
            rc4_pkg::ST_MIX_J:    n_state = rc4_pkg::ST_MIX_SW_N;
            rc4_pkg::ST_MIX_SW_N: n_state = rc4_pkg::ST_MIX_SW_J;
            rc4_pkg::ST_MIX_SW_J: begin
                n_state = (r_n == '1) ? rc4_pkg::ST_SKIP_CHK : rc4_pkg::ST_MIX_RD;
            end
            rc4_pkg::ST_SKIP_CHK: begin
                n_state = (r_skip_cnt == '0) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_RD_I;
            end
            default: n_state = rc4_pkg::ST_CLEAR;
        endcase
    end

    // Outputs: memory controls, adder operands and handshakes.
    always_comb begin
        add_a       = r_a;
        add_b       = r_b;
        add_c       = '0;
        p_we        = 1'b0;
        p_waddr     = r_n;
        p_wdata     = '0;
        p_raddr     = r_n;
        k_we        = 1'b0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            rc4_pkg::ST_CLEAR: begin
                p_we = 1'b1;
            end
            rc4_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                k_we = i_req_valid && (i_req.opcode == rc4_pkg::OP_KEY) && key_room;
            end
            rc4_pkg::ST_KS_RD_I: begin
                add_a   = r_i;
                add_b   = BW'(1);
                p_raddr = sum;
            end
            rc4_pkg::ST_KS_RD_J: begin
                add_a   = r_j;
                add_b   = p_rdata;
                p_raddr = sum;
            end
            rc4_pkg::ST_KS_SW_I: begin
                add_a   = r_a;
                add_b   = p_rdata;
                p_raddr = sum;
                p_we    = 1'b1;
                p_waddr = r_i;
                p_wdata = p_rdata;
            end
            rc4_pkg::ST_KS_SW_J: begin
                p_raddr     = sum;
                p_we        = 1'b1;
                p_waddr     = r_j;
                p_wdata     = r_a;
                o_res_valid = !r_skip;
            end
            rc4_pkg::ST_INIT: begin
                p_we    = 1'b1;
                p_wdata = r_n;
            end
            rc4_pkg::ST_MIX_RD: begin
                p_raddr = r_n;
            end
            rc4_pkg::ST_MIX_J: begin
                add_a   = r_j;
                add_b   = k_rdata;
                add_c   = p_rdata;
                p_raddr = sum;
            end
            rc4_pkg::ST_MIX_SW_N: begin
                p_we    = 1'b1;
                p_wdata = p_rdata;
            end
            rc4_pkg::ST_MIX_SW_J: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_a;
            end
            rc4_pkg::ST_SKIP_CHK: begin
                p_raddr = r_n;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    assign o_res.data_out = r_value ^ ks;
    assign o_res.last_out = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rc4_pkg::ST_CLEAR;
            r_n        <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_kidx     <= '0;
            r_key_len  <= '0;
            r_skip_cnt <= '0;
            r_skip     <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rc4_pkg::ST_CLEAR, rc4_pkg::ST_INIT: begin
                    r_n <= r_n + BW'(1);
                end
                rc4_pkg::ST_IDLE: begin
                    if (req_fire) begin
                        if (i_req.opcode == rc4_pkg::OP_DATA) begin
                            r_skip <= 1'b0;
                        end else begin
                            if (key_room) r_key_len <= r_key_len + LEN_W'(1);
                            if (i_req.last) begin
                                r_n    <= '0;
                                r_j    <= '0;
                                r_kidx <= '0;
                            end
                        end
                    end
                end
                rc4_pkg::ST_KS_RD_I: begin
                    r_i <= sum;
                end
                rc4_pkg::ST_KS_RD_J: begin
                    r_j <= sum;
                end
                rc4_pkg::ST_KS_SW_J: begin
                    if (r_skip) r_skip_cnt <= r_skip_cnt - rc4_pkg::SKIP_W'(1);
                end
                rc4_pkg::ST_MIX_J: begin
                    r_j <= sum;
                end
                rc4_pkg::ST_MIX_SW_J: begin
                    r_n <= r_n + BW'(1);
                    if (LEN_W'(r_kidx) + LEN_W'(1) == r_key_len) begin
                        r_kidx <= '0;
                    end else begin
                        r_kidx <= r_kidx + KA_W'(1);
                    end
                    if (r_n == '1) begin
                        r_i        <= '0;
                        r_j        <= '0;
                        r_skip_cnt <= i_skip_count;
                        r_skip     <= 1'b1;
                    end
                end
                rc4_pkg::ST_SKIP_CHK: begin
                    if (r_skip_cnt == '0) r_key_len <= '0;
                end
                default: begin
                    r_n <= r_n;
                end
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_value <= i_req.value;
            r_last  <= i_req.last;
        end
        if (r_state == rc4_pkg::ST_KS_RD_J || r_state == rc4_pkg::ST_MIX_J) begin
            r_a <= p_rdata;
        end
        if (r_state == rc4_pkg::ST_KS_SW_I) begin
            r_b <= p_rdata;
        end
    end

    a_data_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.opcode == rc4_pkg::OP_DATA) |-> ##4 o_res_valid)
        else $error("data request did not reach the result stage on time");

    a_key_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_len <= LEN_W'(KEY_BYTES))
        else $error("key length ran past the key store");

    a_key_len_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_SKIP_CHK && r_skip_cnt == '0) |=> (r_key_len == '0))
        else $error("key length not cleared after the schedule");

    a_no_result_in_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> !o_res_valid)
        else $error("discarded keystream byte produced a result");

endmodule

// ===== rtl/rc4_keystream_cipher.sv =====
// RC4-drop stream cipher top level: configuration register, output register, rc4_core.
// Depends on rc4_pkg, rc4_core and rc4_ram.
// A data request goes through four permutation RAM steps (read i, read j, swap i, swap j);
// the last step holds until the output register has room, then the core returns to idle.
// A key byte leaves the core idle; the final one runs identity fill, key mixing and the discard.
// After reset, a clearing pass zeroes the permutation before requests are taken.
module rc4_keystream_cipher #(
    parameter int KEY_BYTES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: skip_count.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rc4_pkg::SKIP_W-1:0]  i_cfg_data,
    // Input requests: key bytes and data bytes.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rc4_pkg::t_in                i_in_data,
    // Results: one per data request.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rc4_pkg::t_out               o_out_data
);

    // The skip count is sampled by the core when a key schedule finishes mixing.
    // Writes are always taken; the user must issue them only while the block is idle (not enforced).
    logic [rc4_pkg::SKIP_W-1:0] r_skip_count;

    // The output register decouples the core from the consumer: the core can take
    // the next request while a finished result still waits here.
    logic          r_out_valid;
    rc4_pkg::t_out r_out;

    logic          res_valid;
    logic          res_ready;
    rc4_pkg::t_out res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count <= '0;
        end else if (i_cfg_valid) begin
            r_skip_count <= i_cfg_data;
        end
    end

    rc4_core #(.KEY_BYTES(KEY_BYTES)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_in_valid),
        .o_req_ready  (o_in_ready),
        .i_req        (i_in_data),
        .i_skip_count (r_skip_count),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // The core holds its result stage until this register has room.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/rc4_keystream_cipher_tb.sv =====
// Self-checking bench for rc4_keystream_cipher: key and data requests in, one result per data byte.
// Depends on rc4_pkg and the rc4_keystream_cipher RTL; the expected bytes come from an RC4-drop
// predictor kept inside this bench.
module rc4_keystream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BYTES    = 256;
    localparam int TOTAL_ITEMS  = 1450;
    // This pause is longer than a data request's pass through the core, with room to spare.
    localparam int DRAIN_CYCLES = 16;
    // The slowest legal silence is a final key byte with a discard of 65535: identity fill,
    // key mixing and the full discard. The limit is about three times that silence.
    localparam int STALL_LIMIT  = 1_000_000;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [rc4_pkg::SKIP_W-1:0] i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    rc4_pkg::t_in               i_in_data   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    rc4_pkg::t_out              o_out_data;

    rc4_keystream_cipher #(
        .KEY_BYTES(KEY_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cipher state as the block should hold it. The permutation starts all zero, so the
    // keystream is zero until the first key schedule has run.
    logic [rc4_pkg::BYTE_W-1:0] perm_state [256];
    logic [rc4_pkg::BYTE_W-1:0] key_bytes [KEY_BYTES];
    logic [rc4_pkg::BYTE_W-1:0] ks_i = '0;
    logic [rc4_pkg::BYTE_W-1:0] ks_j = '0;
    int                         key_len = 0;
    logic [rc4_pkg::SKIP_W-1:0] skip_setting = '0;

    rc4_pkg::t_in  pending_requests [$];
    rc4_pkg::t_out expected_results [$];
    int   items_queued   = 0;
    int   items_accepted = 0;
    int   mismatches     = 0;
    int   idle_cycles    = 0;

    // Per-request idling on each side, with occasional stretches where a side never idles.
    int   tx_gap   = 0;
    int   rx_stall = 0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;

    // One PRGA step: advance i, walk j, swap, and return the byte the swapped pair selects.
    function automatic logic [rc4_pkg::BYTE_W-1:0] advance_keystream();
        logic [rc4_pkg::BYTE_W-1:0] a, b, sel;
        ks_i = ks_i + 8'd1;
        a = perm_state[ks_i];
        ks_j = ks_j + a;
        b = perm_state[ks_j];
        perm_state[ks_i] = b;
        perm_state[ks_j] = a;
        sel = a + b;
        return perm_state[sel];
    endfunction

    // Identity permutation, key mixing over the stored bytes, then the configured discard.
    function automatic void run_key_schedule();
        logic [rc4_pkg::BYTE_W-1:0] j, t;
        j = '0;
        for (int n = 0; n < 256; n++) begin
            perm_state[n] = n[rc4_pkg::BYTE_W-1:0];
        end
        for (int n = 0; n < 256; n++) begin
            j = j + key_bytes[n % key_len] + perm_state[n];
            t = perm_state[n];
            perm_state[n] = perm_state[j];
            perm_state[j] = t;
        end
        ks_i = '0;
        ks_j = '0;
        repeat (skip_setting) begin
            void'(advance_keystream());
        end
        key_len = 0;
    endfunction

    // Applied at the edge where a request is accepted. Key bytes past KEY_BYTES are dropped,
    // but a last flag on one of them still starts the schedule.
    task automatic predict_request(input rc4_pkg::t_in req);
        rc4_pkg::t_out want;
        if (req.opcode == rc4_pkg::OP_KEY) begin
            if (key_len < KEY_BYTES) begin
                key_bytes[key_len] = req.value;
                key_len++;
            end
            if (req.last) begin
                run_key_schedule();
            end
        end else begin
            want.data_out = req.value ^ advance_keystream();
            want.last_out = req.last;
            expected_results.push_back(want);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Request driver. The predictor runs here, at the edge of acceptance, so the expected
    // results stay in request order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_request(i_in_data);
                items_accepted++;
            end
            // The slot is free when nothing is offered or the offered request just went in.
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0 || pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (tx_gap > 0) begin
                        tx_gap--;
                    end
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_requests.pop_front();
                    if ($urandom_range(0, 39) == 0) begin
                        tx_burst = !tx_burst;
                    end
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // Result monitor: each accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        rc4_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %02h/%0b with nothing expected",
                                              o_out_data.data_out, o_out_data.last_out));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.data_out !== want.data_out) begin
                        report_mismatch($sformatf("data_out %02h, expected %02h",
                                                  o_out_data.data_out, want.data_out));
                    end
                    if (o_out_data.last_out !== want.last_out) begin
                        report_mismatch($sformatf("last_out %0b, expected %0b",
                                                  o_out_data.last_out, want.last_out));
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_stall = rx_burst ? 0 : $urandom_range(0, 4);
            end
            if (rx_stall > 0) begin
                i_out_ready <= 1'b0;
                rx_stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no request, result or register write moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rc4_keystream_cipher_tb failed");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic op, input logic [rc4_pkg::BYTE_W-1:0] val,
                                 input logic flag);
        rc4_pkg::t_in req;
        req.opcode = op;
        req.value  = val;
        req.last   = flag;
        pending_requests.push_back(req);
        items_queued++;
    endtask

    // A key of random bytes; without the closing flag it stays open and later bytes extend it.
    task automatic queue_key(input int len, input bit closed);
        for (int k = 0; k < len; k++) begin
            queue_request(rc4_pkg::OP_KEY, rc4_pkg::BYTE_W'($urandom_range(0, 255)),
                          closed && (k == len - 1));
        end
    endtask

    // A run of data bytes, flagged last at its end and now and then in the middle.
    task automatic queue_data_run(input int len);
        for (int k = 0; k < len; k++) begin
            queue_request(rc4_pkg::OP_DATA, rc4_pkg::BYTE_W'($urandom_range(0, 255)),
                          (k == len - 1) || ($urandom_range(0, 7) == 0));
        end
    endtask

    // Every phase ends on a data request, so once its result is back the core is idle and
    // the pause only covers the output path.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (items_accepted != items_queued || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_skip(input logic [rc4_pkg::SKIP_W-1:0] count);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        skip_setting = count;
    endtask

    initial begin : stimulus
        int len;
        int pick;
        logic [rc4_pkg::SKIP_W-1:0] skip;
        for (int n = 0; n < 256; n++) begin
            perm_state[n] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Data before any key passes through unchanged while the indices move on.
        queue_request(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        queue_request(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
        queue_request(rc4_pkg::OP_DATA, 8'hA5, 1'b0);
        // Shortest key, with the reset discard of zero.
        queue_request(rc4_pkg::OP_KEY, 8'hFF, 1'b1);
        queue_request(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        queue_request(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
        wait_drained();

        // Largest discard.
        write_skip(16'hFFFF);
        queue_request(rc4_pkg::OP_KEY, 8'h00, 1'b0);
        queue_request(rc4_pkg::OP_KEY, 8'h80, 1'b1);
        queue_request(rc4_pkg::OP_DATA, 8'h3C, 1'b1);
        wait_drained();

        // No discard. Data arrives while a key is half written; then a key follows a key.
        write_skip(16'h0000);
        queue_request(rc4_pkg::OP_KEY, 8'h01, 1'b0);
        queue_request(rc4_pkg::OP_KEY, 8'h02, 1'b0);
        queue_request(rc4_pkg::OP_DATA, 8'h55, 1'b0);
        queue_request(rc4_pkg::OP_KEY, 8'h03, 1'b1);
        queue_request(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
        queue_request(rc4_pkg::OP_DATA, 8'h00, 1'b1);
        queue_request(rc4_pkg::OP_KEY, 8'h7F, 1'b1);
        queue_request(rc4_pkg::OP_KEY, 8'hFE, 1'b0);
        queue_request(rc4_pkg::OP_KEY, 8'h01, 1'b1);
        queue_request(rc4_pkg::OP_DATA, 8'h11, 1'b1);
        wait_drained();

        // Random phases: a new discard each, then several keys each followed by a data run, which may be empty.
        while (items_queued < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       skip = 16'd0;
                1:       skip = 16'd1;
                2:       skip = 16'd256;
                3:       skip = 16'd768;
                4, 5, 6: skip = rc4_pkg::SKIP_W'($urandom_range(0, 64));
                default: skip = rc4_pkg::SKIP_W'($urandom_range(65, 600));
            endcase
            write_skip(skip);
            repeat ($urandom_range(2, 5)) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    // Overlong key: the bytes past the store are dropped.
                    len = $urandom_range(KEY_BYTES + 1, KEY_BYTES + 8);
                end else if (pick == 1) begin
                    len = KEY_BYTES;
                end else if (pick < 4) begin
                    len = $urandom_range(17, KEY_BYTES - 1);
                end else begin
                    len = $urandom_range(1, 16);
                end
                queue_key(len, $urandom_range(0, 7) != 0);
                queue_data_run($urandom_range(0, 40));
            end
            queue_data_run($urandom_range(1, 30));
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("rc4_keystream_cipher_tb passed");
        end else begin
            $display("rc4_keystream_cipher_tb failed");
        end
        $finish;
    end

endmodule
